FILE: rtl/core/ats_pkg.sv
// Shared types and constants for the automatic transfer switch controller.
// Depends on nothing; every other file except ats_stream_if imports it.
`timescale 1ns / 1ps

package ats_pkg;

    // Source codes
    typedef enum logic [1:0] {
        SRC_GRID = 2'd0,
        SRC_GEN  = 2'd1,
        SRC_NONE = 2'd2
    } src_t;

    // Operation codes
    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_MANUAL = 1'b1
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_VOLTAGE_THRESHOLD  = 2'd0,
        CFG_SWITCH_DELAY_TICKS = 2'd1,
        CFG_GRID_STABLE_TICKS  = 2'd2,
        CFG_OVERCURRENT_LIMIT  = 2'd3
    } cfg_idx_t;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [11:0] RST_VOLTAGE_THRESHOLD  = 12'd1800;
    localparam logic [15:0] RST_SWITCH_DELAY_TICKS = 16'd10;
    localparam logic [15:0] RST_GRID_STABLE_TICKS  = 16'd300;
    localparam logic [9:0]  RST_OVERCURRENT_LIMIT  = 10'd200;

    typedef struct packed {
        logic [11:0] voltage_threshold;
        logic [15:0] switch_delay_ticks;
        logic [15:0] grid_stable_ticks;
        logic [9:0]  overcurrent_limit;
    } cfg_t;

    typedef struct packed {
        logic        operation;
        logic [11:0] grid_rms;
        logic [11:0] gen_rms;
        logic [9:0]  load_amps;
        logic        requested_source;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  active_source;
        logic        grid_contactor;
        logic        gen_contactor;
        logic        switched;
        logic        power_failure;
        logic        overcurrent;
        logic [21:0] load_watts;
        logic        indicator_on;
    } out_item_t;

endpackage

FILE: rtl/core/ats_stream_if.sv
// Valid/ready stream interface used for the input and result channels.
// Payload type is a parameter; the channels use structs from ats_pkg.
`timescale 1ns / 1ps

interface ats_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/automatic_transfer_switch_controller.sv
// Top level of the automatic transfer switch controller.
// Depends on ats_pkg, ats_stream_if, ats_cfg_regs, ats_step, ats_out_skid.
//
//   Channel   Direction   Payload      Handshake
//   in_ch     sink        in_item_t    valid/ready
//   out_ch    source      out_item_t   valid/ready
//   cfg       write-only  16-bit data  cfg_we, cfg_index
//
// One transaction per cycle while out_ch keeps taking results. The decision
// and state update finish in the accepting cycle; the result goes to the main
// result register, or to the skid register while the main one holds a stall.
// When out_ch stalls, one more transaction is taken into the skid, then
// in_ch.ready drops. Reset puts the source at none with all counts cleared.
`timescale 1ns / 1ps

module automatic_transfer_switch_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    ats_stream_if.sink                     in_ch,
    ats_stream_if.source                   out_ch,
    input  logic                           cfg_we,
    input  logic [ats_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ats_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ats_pkg::*;

    cfg_t      cfg;
    out_item_t step_result;
    out_item_t out_data;
    logic      can_push;
    logic      accept;
    logic      out_valid;

    assign in_ch.ready = can_push;
    assign accept      = in_ch.valid && can_push;

    ats_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ats_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_ch.payload),
        .cfg    (cfg),
        .result (step_result)
    );

    ats_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_result),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    assign out_ch.valid   = out_valid;
    assign out_ch.payload = out_data;

endmodule

FILE: rtl/core/ats_cfg_regs.sv
// Configuration register file for the transfer switch controller.
// Depends on ats_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module ats_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ats_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ats_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ats_pkg::cfg_t                   cfg
);
    import ats_pkg::*;

    cfg_t cfg_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.voltage_threshold  <= RST_VOLTAGE_THRESHOLD;
            cfg_reg.switch_delay_ticks <= RST_SWITCH_DELAY_TICKS;
            cfg_reg.grid_stable_ticks  <= RST_GRID_STABLE_TICKS;
            cfg_reg.overcurrent_limit  <= RST_OVERCURRENT_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_VOLTAGE_THRESHOLD:  cfg_reg.voltage_threshold  <= cfg_data[11:0];
                CFG_SWITCH_DELAY_TICKS: cfg_reg.switch_delay_ticks <= cfg_data[15:0];
                CFG_GRID_STABLE_TICKS:  cfg_reg.grid_stable_ticks  <= cfg_data[15:0];
                CFG_OVERCURRENT_LIMIT:  cfg_reg.overcurrent_limit  <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/ats_step.sv
// Per-transaction decision logic and controller state (source, dead time,
// grid-good count). Depends on ats_pkg for codes and item structs.
`timescale 1ns / 1ps

module ats_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  ats_pkg::in_item_t item,
    input  ats_pkg::cfg_t     cfg,
    output ats_pkg::out_item_t result
);
    import ats_pkg::*;

    src_t        sel_reg,   sel_next;
    logic [15:0] dead_reg,  dead_next;
    logic [15:0] good_reg,  good_next;

    logic        is_tick;
    logic        grid_ok;
    logic        gen_ok;
    logic [15:0] dead_eff;
    logic        want;
    src_t        target;
    logic        change;
    logic        pfail;
    logic [21:0] power;

    assign is_tick = (op_t'(item.operation) == OP_TICK);
    assign grid_ok = item.grid_rms > cfg.voltage_threshold;
    assign gen_ok  = item.gen_rms  > cfg.voltage_threshold;

    // Advance dead time on ticks only
    assign dead_eff = (is_tick && dead_reg != 16'd0) ? dead_reg - 16'd1 : dead_reg;

    // Count consecutive grid-good ticks, saturating
    always_comb
    begin
        good_next = good_reg;
        if (is_tick)
        begin
            if (!grid_ok)
                good_next = 16'd0;
            else if (good_reg != 16'hFFFF)
                good_next = good_reg + 16'd1;
        end
    end

    // Pick the source to move to, if any
    always_comb
    begin
        want   = 1'b0;
        target = sel_reg;
        pfail  = 1'b0;
        if (!is_tick)
        begin
            want   = 1'b1;
            target = item.requested_source ? SRC_GEN : SRC_GRID;
        end
        else if (grid_ok)
        begin
            if (sel_reg == SRC_NONE ||
                (sel_reg == SRC_GEN && good_next >= cfg.grid_stable_ticks))
            begin
                want   = 1'b1;
                target = SRC_GRID;
            end
        end
        else
        begin
            if (sel_reg == SRC_GRID)
            begin
                want   = 1'b1;
                target = gen_ok ? SRC_GEN : SRC_NONE;
                pfail  = !gen_ok;
            end
            else if (sel_reg == SRC_NONE && gen_ok)
            begin
                want   = 1'b1;
                target = SRC_GEN;
            end
        end
    end

    // Start a change only outside the lockout and to a different source
    assign change    = want && (dead_eff == 16'd0) && (target != sel_reg);
    assign sel_next  = change ? target : sel_reg;
    assign dead_next = change ? cfg.switch_delay_ticks : dead_eff;

    assign power = is_tick ? 22'(item.grid_rms) * 22'(item.load_amps) : 22'd0;

    // Build the result from the updated state
    always_comb
    begin
        result.active_source  = sel_next;
        result.grid_contactor = (sel_next == SRC_GRID) && (dead_next == 16'd0);
        result.gen_contactor  = (sel_next == SRC_GEN)  && (dead_next == 16'd0);
        result.switched       = change;
        result.power_failure  = pfail;
        result.overcurrent    = is_tick && (item.load_amps > cfg.overcurrent_limit)
                                && (sel_next != SRC_NONE);
        result.load_watts     = power;
        result.indicator_on   = (sel_next != SRC_NONE);
    end

    // Hold state; commit on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg  <= SRC_NONE;
            dead_reg <= 16'd0;
            good_reg <= 16'd0;
        end
        else if (accept)
        begin
            sel_reg  <= sel_next;
            dead_reg <= dead_next;
            good_reg <= good_next;
        end
    end

endmodule

FILE: rtl/core/ats_out_skid.sv
// Result register with a skid stage, so input stays open while a result
// waits. Depends on ats_pkg for out_item_t.
`timescale 1ns / 1ps

module ats_out_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ats_pkg::out_item_t push_data,
    output logic               can_push,
    output logic               out_valid,
    input  logic               out_ready,
    output ats_pkg::out_item_t out_data
);
    import ats_pkg::*;

    logic      main_v_reg;
    logic      skid_v_reg;
    out_item_t main_reg;
    out_item_t skid_reg;
    logic      pop;
    logic      load_main;

    assign pop       = main_v_reg && out_ready;
    assign can_push  = !skid_v_reg;
    assign load_main = !main_v_reg || pop;

    // Track which stages hold a transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (pop)
                skid_v_reg <= 1'b0;
        end
        else if (push)
        begin
            if (load_main)
                main_v_reg <= 1'b1;
            else
                skid_v_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_v_reg <= 1'b0;
        end
    end

    // Move payload: skid drains first, otherwise load the new result
    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (load_main)
                main_reg <= push_data;
            else
                skid_reg <= push_data;
        end
    end

    assign out_valid = main_v_reg;
    assign out_data  = main_reg;

endmodule

FILE: rtl/core/ats_checker.sv
// Port-level checks on the result channel of the transfer switch controller.
// Depends on ats_pkg; bound to automatic_transfer_switch_controller below.
`timescale 1ns / 1ps

module ats_port_checks (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input ats_pkg::out_item_t out_item
);
    import ats_pkg::*;

    // Never close both contactors
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.grid_contactor && out_item.gen_contactor))
        else $error("both contactors closed");

    // A closed contactor matches the selected source
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((!out_item.grid_contactor || out_item.active_source == SRC_GRID) &&
                       (!out_item.gen_contactor  || out_item.active_source == SRC_GEN)))
        else $error("contactor does not match active source");

    // Lamp and overcurrent follow source selection
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_item.indicator_on == (out_item.active_source != SRC_NONE)) &&
                       (!out_item.overcurrent || out_item.indicator_on)))
        else $error("indicator or overcurrent inconsistent with source");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

endmodule

bind automatic_transfer_switch_controller ats_port_checks u_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.payload)
);
